### hdl/bfhc_pkg.sv
// ---------------------------------------------------------------------------
// bfhc_pkg
// Shared types, constants and the known-type size lookup for the binary
// frame header checker.
// ---------------------------------------------------------------------------
package bfhc_pkg;

  // header geometry
  localparam int unsigned HDR_LEN    = 8;
  localparam int unsigned HDR_IDX_W  = $clog2(HDR_LEN);
  localparam int unsigned COUNT_W    = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_MAGIC   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_VERSION = 8'd1;
  localparam logic [7:0] MAGIC_RESET   = 8'hBA;
  localparam logic [7:0] VERSION_RESET = 8'h01;

  // result item packing
  localparam int unsigned OUT_TDATA_W = 64;

  // verdict codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_TYPE    = 3'd4,
    ST_LENGTH  = 3'd5
  } status_t;

  // one result item; last member sits in the lowest bits
  typedef struct packed {
    logic [7:0]  body_length;
    logic [31:0] sequence_number;
    logic [7:0]  header_flags;
    logic [7:0]  message_type;
    status_t     status;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

  // verdict handed from the header unit to the output stage
  typedef struct packed {
    logic    valid;
    result_t result;
  } verdict_t;

  // known message types and their exact frame sizes in bytes
  localparam int unsigned NUM_TYPES = 12;
  localparam logic [7:0] KNOWN_TYPE [NUM_TYPES] = '{
    8'h01, 8'h02, 8'h10, 8'h11, 8'h12, 8'h13,
    8'h14, 8'h15, 8'h20, 8'h30, 8'h31, 8'h40
  };
  localparam logic [7:0] KNOWN_SIZE [NUM_TYPES] = '{
    8'd32, 8'd92, 8'd60, 8'd60, 8'd24, 8'd32,
    8'd44, 8'd48, 8'd64, 8'd16, 8'd16, 8'd8
  };

  // frame size of a known type, zero for an unknown one
  function automatic logic [7:0] bfhc_size_of_type(input logic [7:0] type_byte);
    logic [7:0] size;
    size = '0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (type_byte == KNOWN_TYPE[i]) size = size | KNOWN_SIZE[i];
    end
    return size;
  endfunction

endpackage

### hdl/bfhc_hdr.sv
// ---------------------------------------------------------------------------
// bfhc_hdr
// Byte counter, header capture and end-of-frame verdict. The verdict is
// combinational from the stored header and the byte being consumed.
// ---------------------------------------------------------------------------
module bfhc_hdr
  import bfhc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic [7:0] expected_magic,
  input  logic [7:0] expected_version,
  output verdict_t   verdict
);

  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;
  logic [7:0]         header_store [HDR_LEN];
  logic [7:0]         hdr_eff      [HDR_LEN];
  logic               in_header;
  logic [7:0]         type_size;
  logic [31:0]        seq;

  // current byte still lands in the header
  assign in_header = (byte_count < COUNT_W'(HDR_LEN));

  // saturating count including the current byte
  assign byte_count_next = (byte_count == COUNT_MAX) ? COUNT_MAX : byte_count + 1'b1;

  // header as it stands once the current byte is captured
  always_comb begin
    for (int i = 0; i < HDR_LEN; i++) begin
      if (in_header && byte_count[HDR_IDX_W-1:0] == HDR_IDX_W'(i)) hdr_eff[i] = data_byte;
      else hdr_eff[i] = header_store[i];
    end
  end

  assign seq       = {hdr_eff[7], hdr_eff[6], hdr_eff[5], hdr_eff[4]};
  assign type_size = bfhc_size_of_type(hdr_eff[2]);

  // verdict, checks in priority order
  always_comb begin
    verdict       = '0;
    verdict.valid = last_byte;
    if (byte_count_next < COUNT_W'(HDR_LEN)) begin
      verdict.result.status = ST_SHORT;
    end else begin
      verdict.result.message_type    = hdr_eff[2];
      verdict.result.header_flags    = hdr_eff[3];
      verdict.result.sequence_number = seq;
      if (hdr_eff[0] != expected_magic) begin
        verdict.result.status = ST_MAGIC;
      end else if (hdr_eff[1] != expected_version) begin
        verdict.result.status = ST_VERSION;
      end else if (type_size == '0) begin
        verdict.result.status = ST_TYPE;
      end else if (byte_count_next != type_size) begin
        verdict.result.status = ST_LENGTH;
      end else begin
        verdict.result.status      = ST_OK;
        verdict.result.body_length = byte_count_next - COUNT_W'(HDR_LEN);
      end
    end
  end

  // counter and header store; both return to zero after each frame
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      for (int i = 0; i < HDR_LEN; i++) header_store[i] <= '0;
    end else if (step) begin
      if (last_byte) begin
        byte_count <= '0;
        for (int i = 0; i < HDR_LEN; i++) header_store[i] <= '0;
      end else begin
        byte_count <= byte_count_next;
        for (int i = 0; i < HDR_LEN; i++) header_store[i] <= hdr_eff[i];
      end
    end
  end

endmodule

### hdl/binary_frame_header_checker.sv
// ---------------------------------------------------------------------------
// binary_frame_header_checker
// Streams a frame one byte per item, captures the 8-byte header and gives
// one verdict item on the last byte of each frame.
// ---------------------------------------------------------------------------
// Path: the last byte passes the input register, then its verdict is loaded
//   into the result register.
// Throughput: one byte per cycle; a last byte waits in the input register
//   only while an earlier verdict is still held by a low m_tready.
// Reset: rst (synchronous) empties both registers, clears the byte counter
//   and header store, and loads expected magic 0xBA and version 0x01.
module binary_frame_header_checker
  import bfhc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input bytes
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] data_byte
  input  logic                   s_tlast,   // last_byte
  // verdict items
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [2:0] status, [10:3] message_type,
                                            // [18:11] header_flags,
                                            // [50:19] sequence_number,
                                            // [58:51] body_length, [63:59] zero
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  logic       in_valid;
  logic [7:0] in_data;
  logic       in_last;
  logic       advance;
  logic       out_free;
  logic [7:0] expected_magic;
  logic [7:0] expected_version;
  verdict_t   verdict;
  result_t    out_result;

  // configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic   <= MAGIC_RESET;
      expected_version <= VERSION_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EXPECTED_MAGIC:   expected_magic   <= cfg_data;
        REG_EXPECTED_VERSION: expected_version <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: a byte moves on unless it would produce a verdict into a full slot
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  bfhc_hdr u_hdr (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .data_byte        (in_data),
    .last_byte        (in_last),
    .expected_magic   (expected_magic),
    .expected_version (expected_version),
    .verdict          (verdict)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && verdict.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && verdict.valid) out_result <= verdict.result;
  end

  assign m_tdata = {(OUT_TDATA_W - RESULT_W)'(0), out_result};

  // ok verdicts carry a body length matching the known frame size
  a_ok_length: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_result.status == ST_OK) |->
      (bfhc_size_of_type(out_result.message_type) == out_result.body_length + 8'd8))
    else $error("ok verdict with inconsistent body length");

  // short frames report empty header fields
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_result.status == ST_SHORT) |->
      (out_result.message_type == '0 && out_result.header_flags == '0 &&
       out_result.sequence_number == '0))
    else $error("short frame verdict carries header fields");

  // any failure reports zero body length
  a_fail_no_body: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_result.status != ST_OK) |-> (out_result.body_length == '0))
    else $error("failed verdict with non-zero body length");

  // a byte that is not the last never creates a verdict
  a_mid_no_verdict: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_last) |=> (m_tvalid == $past(m_tvalid && !m_tready)))
    else $error("verdict produced without a last byte");

  // a waiting verdict is never overwritten by a new one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(advance && in_last))
    else $error("verdict overwritten while stalled");

endmodule

### tb/bfhc_verdict_checker.sv
// ---------------------------------------------------------------------------
// bfhc_verdict_checker
// Watches the byte, verdict and register channels of the frame header
// checker, predicts the verdict of every frame and compares each verdict
// item with the oldest one owed, field by field.
// ---------------------------------------------------------------------------
module bfhc_verdict_checker
  import bfhc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] data_byte
  input  logic                   s_tlast,   // last_byte
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // [2:0] status, [10:3] message_type,
                                            // [18:11] header_flags,
                                            // [50:19] sequence_number,
                                            // [58:51] body_length, [63:59] zero
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  output int                     errors,
  output int                     verdicts_due,
  output int                     verdicts_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // own copy of the registers and the frame state
  logic [7:0] magic_want;
  logic [7:0] version_want;
  logic [7:0] bytes_seen;
  logic [7:0] hdr_bytes [HDR_LEN];
  result_t    verdicts_owed [$];
  int         mismatches;
  int         compared;

  // exact frame size per known message type, zero when unknown
  function automatic logic [7:0] type_frame_bytes(input logic [7:0] mtype);
    case (mtype)
      8'h01:   return 8'd32;
      8'h02:   return 8'd92;
      8'h10:   return 8'd60;
      8'h11:   return 8'd60;
      8'h12:   return 8'd24;
      8'h13:   return 8'd32;
      8'h14:   return 8'd44;
      8'h15:   return 8'd48;
      8'h20:   return 8'd64;
      8'h30:   return 8'd16;
      8'h31:   return 8'd16;
      8'h40:   return 8'd8;
      default: return 8'd0;
    endcase
  endfunction

  // verdict for a frame of len bytes over the captured header
  function automatic result_t frame_verdict(input logic [7:0] len);
    result_t    r;
    logic [7:0] size;
    r = '0;
    if (len < HDR_LEN) begin
      r.status = ST_SHORT;
    end else begin
      r.message_type    = hdr_bytes[2];
      r.header_flags    = hdr_bytes[3];
      r.sequence_number = {hdr_bytes[7], hdr_bytes[6], hdr_bytes[5], hdr_bytes[4]};
      size = type_frame_bytes(hdr_bytes[2]);
      if (hdr_bytes[0] != magic_want)        r.status = ST_MAGIC;
      else if (hdr_bytes[1] != version_want) r.status = ST_VERSION;
      else if (size == 8'd0)                 r.status = ST_TYPE;
      else if (len != size)                  r.status = ST_LENGTH;
      else begin
        r.status      = ST_OK;
        r.body_length = len - 8'(HDR_LEN);
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int idx,
                             input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: verdict %0d %s expected 0x%0h got 0x%0h",
               $time, idx, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      magic_want   = MAGIC_RESET;
      version_want = VERSION_RESET;
      bytes_seen   = '0;
      foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
      verdicts_owed.delete();
      mismatches = 0;
      compared   = 0;
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_EXPECTED_MAGIC)        magic_want   = cfg_data;
        else if (cfg_index == REG_EXPECTED_VERSION) version_want = cfg_data;
      end

      // byte item: capture header, count with saturation, judge on last
      if (s_tvalid && s_tready) begin
        if (bytes_seen < HDR_LEN) hdr_bytes[bytes_seen[HDR_IDX_W-1:0]] = s_tdata;
        if (bytes_seen != COUNT_MAX) bytes_seen = bytes_seen + 8'd1;
        if (s_tlast) begin
          verdicts_owed.push_back(frame_verdict(bytes_seen));
          bytes_seen = '0;
          foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
        end
      end

      // verdict item against the oldest owed
      if (m_tvalid && m_tready) begin
        if (verdicts_owed.size() == 0) begin
          $display("%0t: verdict 0x%0h arrived with none owed", $time, m_tdata);
          mismatches++;
        end else begin
          want = verdicts_owed.pop_front();
          got  = result_t'(m_tdata[RESULT_W-1:0]);
          check_field("status", compared, want.status, got.status);
          check_field("message_type", compared, want.message_type, got.message_type);
          check_field("header_flags", compared, want.header_flags, got.header_flags);
          check_field("sequence_number", compared, want.sequence_number,
                      got.sequence_number);
          check_field("body_length", compared, want.body_length, got.body_length);
          check_field("padding", compared, '0, m_tdata[OUT_TDATA_W-1:RESULT_W]);
          compared++;
        end
      end
    end
    errors           <= mismatches;
    verdicts_due     <= verdicts_owed.size();
    verdicts_checked <= compared;
  end

endmodule

### tb/tb_binary_frame_header_checker.sv
// ---------------------------------------------------------------------------
// tb_binary_frame_header_checker
// Drives frames of bytes with bursty gaps and a stalling verdict receiver,
// steps the expected magic and version through several settings between
// phases and leaves all prediction and comparison to bfhc_verdict_checker.
// ---------------------------------------------------------------------------
module tb_binary_frame_header_checker
  import bfhc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES   = 250;
  localparam int NUM_PHASES     = 5;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;

  typedef enum int {RX_OPEN, RX_COIN, RX_TIGHT, RX_BEAT} rx_mode_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata   = '0;   // [7:0] data_byte
  logic                   s_tlast   = 1'b0; // last_byte
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;          // [2:0] status ... [58:51] body_length
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data  = '0;

  int         errors;
  int         verdicts_due;
  int         verdicts_checked;
  logic [7:0] cur_magic   = MAGIC_RESET;
  logic [7:0] cur_version = VERSION_RESET;
  int         bytes_sent  = 0;
  int         frames_sent = 0;
  int         reg_writes  = 0;
  int         burst_left  = 0;
  bit         gaps_on     = 1'b1;
  int         quiet_cycles = 0;

  initial forever #5 clk = ~clk;

  binary_frame_header_checker i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bfhc_verdict_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tlast          (s_tlast),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .errors           (errors),
    .verdicts_due     (verdicts_due),
    .verdicts_checked (verdicts_checked)
  );

  // verdict receiver: stall pattern switches between modes of random length
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(40, 300);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:  m_tready <= 1'b1;
      RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
      RX_TIGHT: m_tready <= ($urandom_range(0, 5) == 0);
      default:  m_tready <= (rx_tick % 3 != 0);
    endcase
  end

  // watchdog: too long without any item moving on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL binary_frame_header_checker");
        $finish;
      end
    end
  end

  // one byte item, with bursts and gaps on the sending side
  task automatic push_byte(input logic [7:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  // header packed with byte 0 lowest; body bytes past it are random
  task automatic send_frame(input logic [63:0] header, input int len);
    logic [7:0] b;
    gaps_on = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < len; i++) begin
      if (i < HDR_LEN) b = header[8*i +: 8];
      else b = 8'($urandom);
      push_byte(b, i == len - 1);
    end
    frames_sent++;
  endtask

  function automatic logic [63:0] header_of(input logic [7:0] mag, input logic [7:0] ver,
                                            input logic [7:0] mtype,
                                            input logic [7:0] flags,
                                            input logic [31:0] seq);
    return {seq, flags, mtype, ver, mag};
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_EXPECTED_MAGIC)        cur_magic   = value;
    else if (idx == REG_EXPECTED_VERSION) cur_version = value;
    reg_writes++;
  endtask

  // hold bytes back until every verdict is in, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (verdicts_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed frames, some with one broken header byte, some noise
  task automatic random_frame();
    int         pick;
    int         k;
    int         len;
    logic [7:0] mtype;
    logic [7:0] mag;
    logic [7:0] ver;
    pick = $urandom_range(0, 99);
    mag  = cur_magic;
    ver  = cur_version;
    if (pick < 65) begin
      k     = $urandom_range(0, NUM_TYPES - 1);
      mtype = KNOWN_TYPE[k];
      len   = KNOWN_SIZE[k];
      case ($urandom_range(0, 9))
        0:       len += $urandom_range(1, 3);
        1:       len -= $urandom_range(1, 3);
        default: ;
      endcase
    end else if (pick < 80) begin
      mtype = 8'($urandom);
      len   = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0:       mag = 8'($urandom);
        1:       ver = 8'($urandom);
        default: ;
      endcase
    end else begin
      mag   = 8'($urandom);
      ver   = 8'($urandom);
      mtype = 8'($urandom);
      len   = $urandom_range(1, 12);
    end
    send_frame(header_of(mag, ver, mtype, 8'($urandom), 32'($urandom)), len);
  endtask

  initial begin
    int         phase_start;
    logic [7:0] mag;
    logic [7:0] ver;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register port: both registers plus an index the block must ignore
    write_reg(REG_EXPECTED_MAGIC, MAGIC_RESET);
    write_reg(REG_EXPECTED_VERSION, VERSION_RESET);
    write_reg(8'($urandom_range(2, 255)), 8'($urandom));

    // too short: one byte, then seven
    send_frame(header_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF), 1);
    send_frame(header_of(MAGIC_RESET, VERSION_RESET, 8'h40, 8'hFF, 32'hFFFF_FFFF), 7);
    // header only frames that pass, all-ones and all-zero fields
    send_frame(header_of(MAGIC_RESET, VERSION_RESET, 8'h40, 8'hFF, 32'hFFFF_FFFF), 8);
    send_frame(header_of(MAGIC_RESET, VERSION_RESET, 8'h40, 8'h00, 32'h0000_0000), 8);
    // bad magic, also beating a bad version and unknown type
    send_frame(header_of(8'h00, VERSION_RESET, 8'h40, 8'h5A, 32'h1234_5678), 8);
    send_frame(header_of(8'h00, 8'h00, 8'hFF, 8'hA5, 32'h8000_0001), 8);
    // bad version, beating an unknown type
    send_frame(header_of(MAGIC_RESET, 8'h00, 8'h40, 8'h01, 32'h0102_0304), 8);
    send_frame(header_of(MAGIC_RESET, 8'h02, 8'h00, 8'h80, 32'hFEDC_BA98), 8);
    // unknown types
    send_frame(header_of(MAGIC_RESET, VERSION_RESET, 8'h00, 8'h00, 32'h0), 8);
    send_frame(header_of(MAGIC_RESET, VERSION_RESET, 8'hFF, 8'hFF, 32'hFFFF_FFFF), 16);
    send_frame(header_of(MAGIC_RESET, VERSION_RESET, 8'h03, 8'h33, 32'h5555_AAAA), 32);
    // wrong length, one byte either side
    send_frame(header_of(MAGIC_RESET, VERSION_RESET, 8'h40, 8'h0F, 32'hAAAA_5555), 9);
    send_frame(header_of(MAGIC_RESET, VERSION_RESET, 8'h30, 8'hF0, 32'h0F0F_F0F0), 15);
    // every known type at its exact size
    for (int k = 0; k < NUM_TYPES; k++)
      send_frame(header_of(MAGIC_RESET, VERSION_RESET, KNOWN_TYPE[k], 8'($urandom),
                           32'($urandom)), KNOWN_SIZE[k]);
    // frame long enough to saturate the byte counter
    send_frame(header_of(MAGIC_RESET, VERSION_RESET, 8'h02, 8'h77, 32'hCAFE_0001), 300);

    // random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: begin mag = 8'h00; ver = 8'h00; end
        1: begin mag = 8'hFF; ver = 8'hFF; end
        2: begin mag = MAGIC_RESET; ver = VERSION_RESET; end
        default: begin mag = 8'($urandom); ver = 8'($urandom); end
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(REG_EXPECTED_VERSION, ver);
        write_reg(REG_EXPECTED_MAGIC, mag);
      end else begin
        write_reg(REG_EXPECTED_MAGIC, mag);
        write_reg(REG_EXPECTED_VERSION, ver);
      end
      if ($urandom_range(0, 1)) write_reg(8'($urandom_range(2, 255)), 8'($urandom));
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RANDOM_BYTES / NUM_PHASES) random_frame();
    end

    settle();
    $display("Run covered %0d bytes in %0d frames with %0d register writes",
             bytes_sent, frames_sent, reg_writes);
    $display("%0d verdicts compared, %0d field mismatches", verdicts_checked, errors);
    if (errors == 0 && verdicts_due == 0) begin
      $display("PASS binary_frame_header_checker");
    end else begin
      $display("FAIL binary_frame_header_checker");
    end
    $finish;
  end

endmodule

### sim.f
hdl/bfhc_pkg.sv
hdl/bfhc_hdr.sv
hdl/binary_frame_header_checker.sv
tb/bfhc_verdict_checker.sv
tb/tb_binary_frame_header_checker.sv
